// ===== rtl/srt_pkg.sv =====
package srt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [2:0] CMD_INSERT       = 3'd0;
	localparam logic [2:0] CMD_DELETE       = 3'd1;
	localparam logic [2:0] CMD_PURGE        = 3'd2;
	localparam logic [2:0] CMD_SET_SCORE    = 3'd3;
	localparam logic [2:0] CMD_CLEAR        = 3'd4;
	localparam logic [2:0] CMD_CLEAR_SCORES = 3'd5;
	localparam logic [2:0] CMD_READ         = 3'd6;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [5:0]  index;
		logic [31:0] intensity;
		logic [31:0] retention_time;
		logic [31:0] sigma;
		logic [3:0]  charge_index;
		logic [3:0]  fit_index;
		logic [15:0] score;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  position;
		logic [6:0]  entry_count;
		logic [31:0] out_intensity;
		logic [31:0] out_retention_time;
		logic [31:0] out_sigma;
		logic [3:0]  out_charge_index;
		logic [3:0]  out_fit_index;
		logic [15:0] out_score;
	} res_t;

	// one stored entry
	typedef struct packed {
		logic [31:0] intensity;
		logic [31:0] retention_time;
		logic [31:0] sigma;
		logic [3:0]  charge;
		logic [3:0]  fit;
		logic [15:0] score;
	} entry_t;

endpackage

// ===== rtl/srt_if.sv =====
interface srt_cmd_if;
	logic           valid;
	logic           ready;
	srt_pkg::cmd_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface srt_res_if;
	logic           valid;
	logic           ready;
	srt_pkg::res_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/srt_cmd_fifo.sv =====
// two-entry command queue between front and back
module srt_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  srt_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output srt_pkg::cmd_t rd_data
);
	srt_pkg::cmd_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !wr_ready) else $error("queue overflow");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !rd_valid) else $error("queue underflow");
`endif
endmodule

// ===== rtl/srt_engine.sv =====
// back end: walks the entry memory one entry per cycle
module srt_engine #(
	parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  srt_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output srt_pkg::res_t res
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;  // index compare width

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1; // insert: find spot from top, shifting up
	localparam logic [2:0] S_COMP   = 3'd2; // delete / purge compaction
	localparam logic [2:0] S_CLRSC  = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	srt_pkg::entry_t mem [CAPACITY];

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	srt_pkg::cmd_t cmd_q;
	logic [CW-1:0] rp_q, wp_q;        // write walk pointer; rp_q stays at zero
	logic          rvld_q;            // rdata_q holds entry at rtag_q
	logic [CW-1:0] rtag_q;
	srt_pkg::entry_t rdata_q;
	logic          wen;
	logic [AW-1:0] waddr;
	srt_pkg::entry_t wdata;
	logic          ren;
	logic [AW-1:0] raddr;
	srt_pkg::res_t res_q;
	logic          res_vq;
	logic [XW-1:0] idx_ext;

	assign idx_ext   = XW'(cmd.index);
	assign cmd_ready = (state_q == S_IDLE) && !res_vq;
	assign res_valid = res_vq;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		if (ren) rdata_q <= mem[raddr];
	end

	// walk control
	always_comb begin
		wen   = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		ren   = 1'b0;
		raddr = rp_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ren = cmd_valid && cmd_ready;
				case (cmd.command) inside
					srt_pkg::CMD_INSERT: raddr = AW'(count_q - CW'(1));
					srt_pkg::CMD_DELETE: raddr = AW'(idx_ext + XW'(1));
					srt_pkg::CMD_PURGE, srt_pkg::CMD_CLEAR_SCORES: raddr = '0;
					default: raddr = AW'(idx_ext);
				endcase
			end
			S_SCAN: if (rvld_q && count_q != '0) begin
				// rdata_q = entry at rtag_q; wp_q = free slot above it
				wen   = 1'b1;
				waddr = wp_q[AW-1:0];
				if (cmd_q.intensity > rdata_q.intensity) begin
					wdata = '{cmd_q.intensity, cmd_q.retention_time, cmd_q.sigma,
						cmd_q.charge_index, cmd_q.fit_index, 16'd0};
				end else begin
					ren   = (rtag_q != '0);
					raddr = AW'(rtag_q - CW'(1));
				end
			end
			S_COMP: if (rvld_q) begin
				if (cmd_q.command == srt_pkg::CMD_DELETE || rdata_q.score != 16'd0) begin
					wen   = 1'b1;
					waddr = wp_q[AW-1:0];
				end
				ren   = (rtag_q + CW'(1) < count_q);
				raddr = AW'(rtag_q + CW'(1));
			end
			S_CLRSC: if (rvld_q) begin
				wen         = 1'b1;
				waddr       = rtag_q[AW-1:0];
				wdata.score = 16'd0;
				ren         = (rtag_q + CW'(1) < count_q);
				raddr       = AW'(rtag_q + CW'(1));
			end
			S_RDWAIT: begin
				// bottom-slot insert and set-score writes
				if (cmd_q.command == srt_pkg::CMD_INSERT) begin
					wen   = 1'b1;
					waddr = '0;
					wdata = '{cmd_q.intensity, cmd_q.retention_time, cmd_q.sigma,
						cmd_q.charge_index, cmd_q.fit_index, 16'd0};
				end else if (cmd_q.command == srt_pkg::CMD_SET_SCORE) begin
					wen         = 1'b1;
					waddr       = AW'(cmd_q.index);
					wdata.score = cmd_q.score;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cmd_q   <= '0;
			res_q   <= '0;
			res_vq  <= 1'b0;
			rvld_q  <= 1'b0;
			rtag_q  <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
		end else begin
			if (res_vq && res_ready) res_vq <= 1'b0;
			rvld_q <= ren;
			if (ren) rtag_q <= CW'(raddr);
			unique case (state_q)
				S_IDLE: if (cmd_valid && cmd_ready) begin
					cmd_q <= cmd;
					res_q <= '0;
					unique case (cmd.command)
						srt_pkg::CMD_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								res_q.status <= srt_pkg::ST_FULL;
								state_q      <= S_DONE;
							end else if (count_q == '0) begin
								state_q <= S_SCAN;
								wp_q    <= '0;
							end else begin
								state_q <= S_SCAN;
								wp_q    <= count_q;
							end
						end
						srt_pkg::CMD_DELETE: begin
							if (idx_ext >= XW'(count_q)) begin
								res_q.status <= srt_pkg::ST_BAD_INDEX;
								state_q      <= S_DONE;
							end else if (idx_ext + XW'(1) == XW'(count_q)) begin
								count_q <= count_q - CW'(1);
								state_q <= S_DONE;
							end else begin
								wp_q    <= CW'(idx_ext);
								state_q <= S_COMP;
							end
						end
						srt_pkg::CMD_PURGE: begin
							wp_q    <= '0;
							state_q <= (count_q == '0) ? S_DONE : S_COMP;
						end
						srt_pkg::CMD_SET_SCORE: begin
							if (idx_ext >= XW'(count_q)) begin
								res_q.status <= srt_pkg::ST_BAD_INDEX;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RDWAIT;
							end
						end
						srt_pkg::CMD_CLEAR: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
						srt_pkg::CMD_CLEAR_SCORES:
							state_q <= (count_q == '0) ? S_DONE : S_CLRSC;
						srt_pkg::CMD_READ: begin
							if (idx_ext >= XW'(count_q)) begin
								res_q.status <= srt_pkg::ST_BAD_INDEX;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RDWAIT;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SCAN: begin
					if (count_q == '0 || (!rvld_q && !ren && wp_q == '0)) begin
						// empty table, or walked past the bottom: land at 0
						state_q <= S_RDWAIT;
					end else if (rvld_q) begin
						if (cmd_q.intensity > rdata_q.intensity) begin
							res_q.position <= 6'(wp_q);
							count_q        <= count_q + CW'(1);
							state_q        <= S_DONE;
						end else begin
							wp_q <= wp_q - CW'(1);
							if (rtag_q == '0) state_q <= S_RDWAIT;
						end
					end
				end
				S_COMP: if (rvld_q) begin
					if (cmd_q.command == srt_pkg::CMD_DELETE || rdata_q.score != 16'd0)
						wp_q <= wp_q + CW'(1);
					if (rtag_q + CW'(1) >= count_q) begin
						state_q <= S_DONE;
						if (cmd_q.command == srt_pkg::CMD_DELETE)
							count_q <= count_q - CW'(1);
						else
							count_q <= wp_q + ((rdata_q.score != 16'd0) ? CW'(1) : CW'(0));
					end
				end
				S_CLRSC: if (rvld_q && rtag_q + CW'(1) >= count_q) state_q <= S_DONE;
				S_RDWAIT: begin
					state_q <= S_DONE;
					if (cmd_q.command == srt_pkg::CMD_INSERT) begin
						// position 0 write
						res_q.position <= '0;
						count_q        <= count_q + CW'(1);
					end else if (cmd_q.command == srt_pkg::CMD_READ) begin
						res_q.out_intensity      <= rdata_q.intensity;
						res_q.out_retention_time <= rdata_q.retention_time;
						res_q.out_sigma          <= rdata_q.sigma;
						res_q.out_charge_index   <= rdata_q.charge;
						res_q.out_fit_index      <= rdata_q.fit;
						res_q.out_score          <= rdata_q.score;
					end
				end
				S_DONE: begin
					res_q.entry_count <= 7'(count_q);
					res_vq            <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("count above capacity");
	a_res_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_vq |-> state_q == S_IDLE) else $error("result while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> res_vq) else $error("result not raised");
`endif
endmodule

// ===== rtl/sorted_result_table.sv =====
// Sorted result table: holds up to CAPACITY fit results in ascending order
// of intensity in one entry memory. Commands arrive as beats on cmd_in and
// each gives one result beat on res_out. A small command queue decouples
// the input from the walker, so a producer can hand over two commands while
// one executes. Clear and bad-index/full results go straight to the done
// state; read and set score pass a wait state; insert, delete, purge and
// clear scores walk the memory one entry per cycle via its single read port.
module sorted_result_table #(
	parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srt_cmd_if.sink    cmd_in,
	srt_res_if.source  res_out
);
	logic          q_valid, q_ready;
	srt_pkg::cmd_t q_data;

	// front: queue incoming beats
	srt_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(cmd_in.valid), .wr_ready(cmd_in.ready), .wr_data(cmd_in.payload),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	// back: executes one command at a time
	srt_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_data),
		.res_valid(res_out.valid), .res_ready(res_out.ready), .res(res_out.payload)
	);

`ifndef SYNTHESIS
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_in.valid && !cmd_in.ready |=> cmd_in.valid) else $error("cmd beat dropped");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.payload))
		else $error("result beat changed");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> !q_ready) else $error("engine took command under result");
`endif
endmodule
